@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on the rising edge and
// disabled while the active-low synchronous reset is asserted.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every edge outside reset.
`define CHK_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be seen outside reset.
`define CHK_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ sv/ndaw_pkg.sv @@
// ----------------------------------------------------------------------------
// ndaw_pkg
// Types and constants shared by the N-d array address walker.
// ----------------------------------------------------------------------------
package ndaw_pkg;

    localparam int NDIM     = 3;
    localparam int COORD_W  = 16;
    localparam int OFFSET_W = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Operation codes
    localparam logic [1:0] FUNC_LOAD    = 2'd0;
    localparam logic [1:0] FUNC_ADVANCE = 2'd1;
    localparam logic [1:0] FUNC_SKIP    = 2'd2;

    // Status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_RANGE   = 3'd1;
    localparam logic [2:0] ST_SCALAR  = 3'd2;
    localparam logic [2:0] ST_END     = 3'd3;
    localparam logic [2:0] ST_TOOMANY = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DIMS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LB0  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UB0  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LB1  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UB1  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LB2  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_UB2  = 3'd6;

    typedef struct packed {
        logic [1:0]                func;
        logic [1:0]                given_count;
        logic signed [COORD_W-1:0] start_coord_0;
        logic signed [COORD_W-1:0] start_coord_1;
        logic signed [COORD_W-1:0] start_coord_2;
        logic [1:0]                skip_len;
    } t_in_item;

    typedef struct packed {
        logic [OFFSET_W-1:0]       linear_offset;
        logic signed [COORD_W-1:0] coord_out_0;
        logic signed [COORD_W-1:0] coord_out_1;
        logic signed [COORD_W-1:0] coord_out_2;
        logic [2:0]                status;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_MUL,
        S_ADD,
        S_DONE
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic exec;
        logic mul;
        logic add;
        logic done;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic go_loop;   // offset needs a Horner pass over at least one dimension
        logic last_step; // final dimension of the pass
    } t_dp_stat;

endpackage

@@ sv/ndaw_ctrl.sv @@
// ----------------------------------------------------------------------------
// ndaw_ctrl
// Sequencer: accept, execute, offset loop, result hand-over.
// ----------------------------------------------------------------------------
module ndaw_ctrl import ndaw_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_stat.go_loop ? S_MUL : S_DONE;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_ADD;
            end
            S_ADD: begin
                o_cmd.add = 1'b1;
                n_state   = i_stat.last_step ? S_DONE : S_MUL;
            end
            S_DONE: begin
                // wait for the output register to free up
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.done = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_out_valid = o_cmd.done | (r_out_valid & i_out_stall);
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

@@ sv/ndaw_datapath.sv @@
// ----------------------------------------------------------------------------
// ndaw_datapath
// Config registers, coordinate/offset state, step logic and the shared
// multiply-add used for Horner evaluation of the column-major offset.
// ----------------------------------------------------------------------------
module ndaw_datapath import ndaw_pkg::*; #(
    parameter int MAX_DIMS    = 3,
    parameter int OFFSET_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_in_item              i_in_data,
    input  t_dp_cmd               i_cmd,
    output t_dp_stat              o_stat,
    output t_out_item             o_out_data
);

    localparam int OB = OFFSET_BITS;

    logic [1:0]                r_dims;
    logic signed [COORD_W-1:0] r_lb    [NDIM];
    logic signed [COORD_W-1:0] r_ub    [NDIM];
    logic signed [COORD_W-1:0] r_coord [NDIM];
    logic [OB-1:0]             r_offset;

    t_in_item      r_in;
    logic [2:0]    r_status;
    logic          r_recomp;
    logic [OB-1:0] r_acc;
    logic [OB-1:0] r_prod;
    logic [1:0]    r_idx;
    t_out_item     r_out;

    logic [1:0]                w_n;
    logic signed [COORD_W-1:0] x_coord [NDIM];
    logic [2:0]                x_status;
    logic                      x_commit;
    logic                      x_recomp;
    logic                      x_incr;

    logic [1:0]    w_sel;
    logic [31:0]   w_diff32;
    logic [31:0]   w_ext32;
    logic [OB-1:0] w_diff;
    logic [OB-1:0] w_ext;
    logic [OB-1:0] w_prod;
    logic [OB-1:0] w_final;

    assign w_n = (r_dims > 2'(MAX_DIMS)) ? 2'(MAX_DIMS) : r_dims;

    // ---- configuration ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dims <= '0;
            for (int d = 0; d < NDIM; d++) begin
                r_lb[d] <= '0;
                r_ub[d] <= '0;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DIMS: r_dims  <= i_cfg_data[1:0];
                CFG_LB0:  r_lb[0] <= i_cfg_data;
                CFG_UB0:  r_ub[0] <= i_cfg_data;
                CFG_LB1:  r_lb[1] <= i_cfg_data;
                CFG_UB1:  r_ub[1] <= i_cfg_data;
                CFG_LB2:  r_lb[2] <= i_cfg_data;
                CFG_UB2:  r_ub[2] <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // ---- step logic: new coordinates and status from the captured item ----
    always_comb begin
        logic signed [COORD_W-1:0] sc [NDIM];
        logic [1:0] first;
        logic       ok;
        logic       any_below;
        logic       all_low;

        sc[0] = r_in.start_coord_0;
        sc[1] = r_in.start_coord_1;
        sc[2] = r_in.start_coord_2;
        first     = '0;
        ok        = 1'b1;
        any_below = 1'b0;
        all_low   = 1'b1;
        for (int d = 0; d < NDIM; d++) x_coord[d] = r_coord[d];
        x_status = ST_OK;
        x_commit = 1'b0;
        x_recomp = 1'b0;
        x_incr   = 1'b0;

        case (r_in.func)
            FUNC_LOAD: begin
                if (r_in.given_count > w_n) begin
                    x_status = ST_TOOMANY;
                end else begin
                    first = w_n - r_in.given_count;
                    for (int d = 0; d < NDIM; d++) begin
                        if (2'(d) >= w_n) begin
                            x_coord[d] = '0;
                        end else if (2'(d) < first) begin
                            x_coord[d] = r_lb[d];
                        end else begin
                            x_coord[d] = sc[d];
                            if (sc[d] < r_lb[d] || sc[d] > r_ub[d]) ok = 1'b0;
                        end
                    end
                    if (ok) begin
                        x_commit = 1'b1;
                        x_recomp = 1'b1;
                    end else begin
                        x_status = ST_RANGE;
                    end
                end
            end
            FUNC_ADVANCE: begin
                if (w_n == 2'd0) begin
                    x_status = ST_SCALAR;
                end else begin
                    for (int d = 0; d < NDIM; d++)
                        if (2'(d) < w_n && r_coord[d] < r_ub[d]) any_below = 1'b1;
                    if (!any_below) begin
                        x_status = ST_END;
                    end else begin
                        x_commit   = 1'b1;
                        x_incr     = 1'b1;
                        x_coord[0] = x_coord[0] + 16'sd1;
                        for (int d = 0; d < NDIM - 1; d++) begin
                            if (2'(d + 1) < w_n && x_coord[d] > r_ub[d]) begin
                                x_coord[d + 1] = x_coord[d + 1] + 16'sd1;
                                x_coord[d]     = r_lb[d];
                            end
                        end
                    end
                end
            end
            FUNC_SKIP: begin
                if (w_n == 2'd0) begin
                    x_status = ST_SCALAR;
                end else begin
                    x_commit = 1'b1;
                    x_recomp = 1'b1;
                    if (r_in.skip_len >= w_n) begin
                        // close every dimension: last one goes one past its end
                        for (int d = 0; d < NDIM; d++) begin
                            if (2'(d + 1) < w_n)  x_coord[d] = r_lb[d];
                            if (2'(d + 1) == w_n) x_coord[d] = r_ub[d] + 16'sd1;
                        end
                    end else begin
                        for (int d = 0; d < NDIM; d++) begin
                            if (2'(d) < r_in.skip_len) begin
                                if (x_coord[d] != r_lb[d]) all_low = 1'b0;
                                x_coord[d] = r_lb[d];
                            end
                        end
                        if (!all_low) begin
                            for (int d = 0; d < NDIM; d++)
                                if (2'(d) == r_in.skip_len) x_coord[d] = x_coord[d] + 16'sd1;
                            for (int d = 0; d < NDIM - 1; d++) begin
                                if (2'(d) >= r_in.skip_len && 2'(d + 1) < w_n &&
                                    x_coord[d] > r_ub[d]) begin
                                    x_coord[d + 1] = x_coord[d + 1] + 16'sd1;
                                    x_coord[d]     = r_lb[d];
                                end
                            end
                        end
                    end
                    for (int d = 0; d < NDIM; d++)
                        if (2'(d) < w_n && (x_coord[d] < r_lb[d] || x_coord[d] > r_ub[d]))
                            x_status = ST_END;
                end
            end
            default: begin
            end
        endcase
    end

    // ---- Horner term select: acc = acc * extent[idx-1] + diff[idx-1] ----
    assign w_sel    = r_idx - 2'd1;
    assign w_diff32 = {{16{r_coord[w_sel][COORD_W-1]}}, r_coord[w_sel]}
                    - {{16{r_lb[w_sel][COORD_W-1]}}, r_lb[w_sel]};
    assign w_ext32  = {{16{r_ub[w_sel][COORD_W-1]}}, r_ub[w_sel]}
                    - {{16{r_lb[w_sel][COORD_W-1]}}, r_lb[w_sel]} + 32'd1;
    assign w_diff   = w_diff32[OB-1:0];
    assign w_ext    = w_ext32[OB-1:0];
    assign w_prod   = r_acc * w_ext;
    assign w_final  = r_recomp ? r_acc : r_offset;

    assign o_stat.go_loop   = x_recomp && (w_n != 2'd0);
    assign o_stat.last_step = (r_idx == 2'd1);

    // ---- architectural state ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int d = 0; d < NDIM; d++) r_coord[d] <= '0;
            r_offset <= '0;
        end else begin
            if (i_cmd.exec && x_commit)
                for (int d = 0; d < NDIM; d++) r_coord[d] <= x_coord[d];
            if (i_cmd.exec && x_incr)
                r_offset <= r_offset + OB'(1);
            if (i_cmd.done && r_recomp)
                r_offset <= r_acc;
        end
    end

    // ---- working registers ----
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) r_in <= i_in_data;
        if (i_cmd.exec) begin
            r_status <= x_status;
            r_recomp <= x_recomp;
            r_acc    <= '0;
            r_idx    <= w_n;
        end
        if (i_cmd.mul) r_prod <= w_prod;
        if (i_cmd.add) begin
            r_acc <= r_prod + w_diff;
            r_idx <= r_idx - 2'd1;
        end
        if (i_cmd.done) begin
            r_out.linear_offset <= OFFSET_W'(w_final);
            r_out.coord_out_0   <= r_coord[0];
            r_out.coord_out_1   <= r_coord[1];
            r_out.coord_out_2   <= r_coord[2];
            r_out.status        <= r_status;
        end
    end

    assign o_out_data = r_out;

endmodule

@@ sv/nd_array_address_walker_core.sv @@
// ----------------------------------------------------------------------------
// nd_array_address_walker_core
// Column-major address walker for arrays of up to three dimensions: load,
// advance and skip operations on a coordinate, each giving one result.
// ----------------------------------------------------------------------------
//
//  channel  | valid        | stall        | payload
//  ---------+--------------+--------------+-------------------------------
//  input    | i_in_valid   | o_in_stall   | i_in_data  (t_in_item)
//  output   | o_out_valid  | i_out_stall  | o_out_data (t_out_item)
//  config   | i_cfg_we     | (none)       | i_cfg_idx, i_cfg_data
//
//  Advance and status-only cases go straight from the execute step to the
//  hand-over step; load and skip first rebuild the offset with one shared
//  multiply-add unit, one dimension in use per multiply/add step pair.
//  Reset is synchronous, active low; it clears config, coordinates, offset.
//  A result waits in the output register while the next input is taken.
//  A stalled output only holds the block at the hand-over step.
//
module nd_array_address_walker_core import ndaw_pkg::*; #(
    parameter int MAX_DIMS    = 3,
    parameter int OFFSET_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input item channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_data,
    // result channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_data,
    // configuration writes
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // Sequencer: IDLE takes a transfer, EXEC commits the step, MUL/ADD run the
    // offset loop, DONE loads the output register.
    ndaw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // Coordinate state, bounds and the multiply-add.
    ndaw_datapath #(
        .MAX_DIMS    (MAX_DIMS),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_data  (i_in_data),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .o_out_data (o_out_data)
    );

endmodule

@@ sv/ndaw_checker.sv @@
// ----------------------------------------------------------------------------
// ndaw_checker
// Port-level checks for the address walker, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ndaw_checker import ndaw_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_data
);

    // one item in flight: a transfer closes the input side next cycle
    `CHK_ASSERT(a_one_in_flight, i_clk, i_rst_n, (i_in_valid && !o_in_stall) |=> o_in_stall, "input taken while busy")

    // a new result only appears out of a busy cycle
    `CHK_ASSERT(a_result_from_work, i_clk, i_rst_n, $rose(o_out_valid) |-> $past(o_in_stall), "result without work")

    // status codes stay within the defined set
    `CHK_NEVER(a_status_code, i_clk, i_rst_n, o_out_valid && (o_out_data.status > ST_TOOMANY), "bad status code")

    // a stalled result is not dropped
    `CHK_ASSERT(a_out_hold, i_clk, i_rst_n, (o_out_valid && i_out_stall) |=> o_out_valid, "result dropped")

endmodule

bind nd_array_address_walker_core ndaw_checker u_ndaw_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
